FILE: rtl/core/stts_pkg.sv
// Shared types and constants for the scene text token scanner.
// Used by stts_front, stts_queue, stts_back and scene_text_token_scanner.
`timescale 1ns / 1ps
`default_nettype none

package stts_pkg;

  localparam int MAX_LINE    = 1024;
  localparam int COL_W       = $clog2(MAX_LINE);
  localparam int LEN_W       = COL_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  localparam int START_W     = 10;
  localparam int VLEN_W      = 11;
  localparam int KIND_W      = 3;
  localparam int OUT_DATA_W  = 24;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_KEYWORD,
    MODE_NUMBER,
    MODE_STRING
  } scan_mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_KEYWORD,
    KIND_VALUE_KEYWORD,
    KIND_OPEN_BRACE,
    KIND_CLOSE_BRACE,
    KIND_REAL,
    KIND_INTEGER,
    KIND_STRING
  } token_kind_t;

  typedef struct packed {
    token_kind_t      kind;
    logic [COL_W-1:0] start;
    logic [COL_W-1:0] stop;
    logic             add_one;
    logic             colon;
  } stts_event_t;

endpackage

`default_nettype wire

FILE: rtl/core/stts_front.sv
// Front end: per-character scan state machine that classifies each word.
// Emits one token event per completed token; depends on stts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stts_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_char,
  input  wire logic                 in_end,
  input  wire logic                 queue_full,
  output logic                      push,
  output stts_pkg::stts_event_t     push_data
);

  stts_pkg::scan_mode_t           mode, mode_next;
  logic [stts_pkg::COL_W-1:0]     column, column_next;
  logic [stts_pkg::COL_W-1:0]     token_start, token_start_next;
  logic                           seen_dot, seen_dot_next;
  logic                           last_was_colon, last_was_colon_next;
  logic [stts_pkg::COL_W-1:0]     col_inc;
  logic                           accept;
  logic                           ev_hit;
  logic                           is_ws, is_colon, is_num_start, dot_upd;
  stts_pkg::token_kind_t          open_kind;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && ev_hit;

  always_comb begin
    col_inc = (column < stts_pkg::COL_W'(stts_pkg::MAX_LINE - 1)) ?
              column + 1'b1 : stts_pkg::COL_W'(stts_pkg::MAX_LINE - 1);
    is_ws        = (in_char == stts_pkg::CH_SPACE) || (in_char == stts_pkg::CH_TAB);
    is_colon     = (in_char == stts_pkg::CH_COLON);
    is_num_start = (in_char == stts_pkg::CH_MINUS) ||
                   ((in_char >= stts_pkg::CH_ZERO) && (in_char <= stts_pkg::CH_NINE));
    dot_upd      = seen_dot || ((mode == stts_pkg::MODE_NUMBER) &&
                                (in_char == stts_pkg::CH_DOT) && !is_ws);

    mode_next           = mode;
    token_start_next    = token_start;
    seen_dot_next       = seen_dot;
    last_was_colon_next = last_was_colon;
    ev_hit              = 1'b0;
    push_data.kind      = stts_pkg::KIND_KEYWORD;
    push_data.start     = column;
    push_data.stop      = column;
    push_data.add_one   = 1'b0;
    push_data.colon     = 1'b0;

    if (mode == stts_pkg::MODE_KEYWORD) begin
      open_kind = stts_pkg::KIND_KEYWORD;
    end else if (dot_upd) begin
      open_kind = stts_pkg::KIND_REAL;
    end else begin
      open_kind = stts_pkg::KIND_INTEGER;
    end

    case (mode)
      stts_pkg::MODE_IDLE: begin
        if (in_char == stts_pkg::CH_STAR || in_char == stts_pkg::CH_QUOTE) begin
          if (in_end) begin
            ev_hit          = 1'b1;
            push_data.kind  = (in_char == stts_pkg::CH_STAR) ?
                              stts_pkg::KIND_KEYWORD : stts_pkg::KIND_STRING;
            push_data.start = col_inc;
            push_data.stop  = col_inc;
          end else begin
            token_start_next    = col_inc;
            last_was_colon_next = 1'b0;
            seen_dot_next       = 1'b0;
            mode_next           = (in_char == stts_pkg::CH_STAR) ?
                                  stts_pkg::MODE_KEYWORD : stts_pkg::MODE_STRING;
          end
        end else if (in_char == stts_pkg::CH_LBRACE) begin
          ev_hit         = 1'b1;
          push_data.kind = stts_pkg::KIND_OPEN_BRACE;
        end else if (in_char == stts_pkg::CH_RBRACE) begin
          ev_hit         = 1'b1;
          push_data.kind = stts_pkg::KIND_CLOSE_BRACE;
        end else if (is_num_start) begin
          if (in_end) begin
            ev_hit            = 1'b1;
            push_data.kind    = stts_pkg::KIND_INTEGER;
            push_data.add_one = 1'b1;
          end else begin
            token_start_next    = column;
            last_was_colon_next = 1'b0;
            seen_dot_next       = 1'b0;
            mode_next           = stts_pkg::MODE_NUMBER;
          end
        end
      end
      stts_pkg::MODE_STRING: begin
        push_data.kind  = stts_pkg::KIND_STRING;
        push_data.start = token_start;
        if (in_char == stts_pkg::CH_QUOTE) begin
          ev_hit          = 1'b1;
          push_data.colon = last_was_colon;
          mode_next       = stts_pkg::MODE_IDLE;
        end else begin
          last_was_colon_next = is_colon;
          if (in_end) begin
            ev_hit            = 1'b1;
            push_data.add_one = 1'b1;
            push_data.colon   = is_colon;
          end
        end
      end
      default: begin
        push_data.kind  = open_kind;
        push_data.start = token_start;
        if (is_ws) begin
          ev_hit          = 1'b1;
          push_data.colon = last_was_colon;
          mode_next       = stts_pkg::MODE_IDLE;
        end else begin
          seen_dot_next       = dot_upd;
          last_was_colon_next = is_colon;
          if (in_end) begin
            ev_hit            = 1'b1;
            push_data.add_one = 1'b1;
            push_data.colon   = is_colon;
          end
        end
      end
    endcase

    if (in_end) begin
      mode_next           = stts_pkg::MODE_IDLE;
      column_next         = '0;
      seen_dot_next       = 1'b0;
      last_was_colon_next = 1'b0;
    end else begin
      column_next = col_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= stts_pkg::MODE_IDLE;
      column         <= '0;
      token_start    <= '0;
      seen_dot       <= 1'b0;
      last_was_colon <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      column         <= column_next;
      token_start    <= token_start_next;
      seen_dot       <= seen_dot_next;
      last_was_colon <= last_was_colon_next;
    end
  end

  a_line_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && in_end |=> (mode == stts_pkg::MODE_IDLE) && (column == '0))
    else $error("scan state not cleared after line end");

endmodule

`default_nettype wire

FILE: rtl/core/stts_queue.sv
// Short FIFO of token events between the front end and the back end.
// Depends on stts_pkg for the event type and depth.
`timescale 1ns / 1ps
`default_nettype none

module stts_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire stts_pkg::stts_event_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output stts_pkg::stts_event_t     head_data
);

  stts_pkg::stts_event_t          entries [stts_pkg::QUEUE_DEPTH];
  logic [stts_pkg::QA_W-1:0]      wr_ptr, rd_ptr;
  logic [stts_pkg::QA_W:0]        count;

  assign full       = (count == (stts_pkg::QA_W+1)'(stts_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/core/stts_back.sv
// Back end: turns a token event into a descriptor and holds it in the output register.
// Computes the value length and the value keyword fold; depends on stts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stts_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            head_valid,
  input  wire stts_pkg::stts_event_t           head_data,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output stts_pkg::token_kind_t                out_kind,
  output logic [stts_pkg::START_W-1:0]         out_start,
  output logic [stts_pkg::VLEN_W-1:0]          out_length
);

  logic [stts_pkg::LEN_W-1:0] raw_len, len_next;
  stts_pkg::token_kind_t      kind_next;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    raw_len = {1'b0, head_data.stop} - {1'b0, head_data.start} +
              stts_pkg::LEN_W'(head_data.add_one);
    kind_next = head_data.kind;
    len_next  = raw_len;
    if (raw_len != '0 && head_data.colon) begin
      kind_next = stts_pkg::KIND_VALUE_KEYWORD;
      len_next  = raw_len - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind   <= kind_next;
      out_start  <= stts_pkg::START_W'(head_data.start);
      out_length <= stts_pkg::VLEN_W'(len_next);
    end
  end

  a_brace_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == stts_pkg::KIND_OPEN_BRACE ||
                  out_kind == stts_pkg::KIND_CLOSE_BRACE) |-> out_length == '0)
    else $error("brace descriptor with nonzero length");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pop |-> raw_len <= stts_pkg::LEN_W'(stts_pkg::MAX_LINE))
    else $error("token length beyond line limit");

endmodule

`default_nettype wire

FILE: rtl/core/scene_text_token_scanner.sv
// Top level of the scene text token scanner.
// Instantiates stts_front, stts_queue and stts_back; depends on stts_pkg.
//
// Takes one character word per cycle while the event queue is not full, with tlast on
// the last character of a line, and returns one descriptor word per completed token:
// kind in tuser, start column and value length in tdata. A character is scanned by the
// front scan state machine; the event of a closing character is registered in the event
// queue and then in the output register before its descriptor is offered, and the
// four-entry event queue keeps input flowing while the output side stalls, until four
// events wait. Columns saturate at MAX_LINE-1.
`timescale 1ns / 1ps
`default_nettype none

module scene_text_token_scanner (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,   // text_char
  input  wire logic                              s_axis_tlast,   // line_end
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [stts_pkg::OUT_DATA_W-1:0]        m_axis_tdata,   // start_column, value_length
  output logic [stts_pkg::KIND_W-1:0]            m_axis_tuser    // token_kind
);

  logic                                  push, full, pop, head_valid;
  stts_pkg::stts_event_t                 push_data, head_data;
  stts_pkg::token_kind_t                 out_kind;
  logic [stts_pkg::START_W-1:0]          out_start;
  logic [stts_pkg::VLEN_W-1:0]           out_length;

  stts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_char    (s_axis_tdata),
    .in_end     (s_axis_tlast),
    .queue_full (full),
    .push       (push),
    .push_data  (push_data)
  );

  stts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  stts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (out_kind),
    .out_start  (out_start),
    .out_length (out_length)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {
    (stts_pkg::OUT_DATA_W - stts_pkg::START_W - stts_pkg::VLEN_W)'(0),
    out_length,
    out_start
  };

endmodule

`default_nettype wire

FILE: tb/token_descriptor_checker.sv
// Checker for the scene text token scanner: watches both stream channels,
// predicts token descriptors from the accepted characters and compares them.
// Depends on stts_pkg for the kind and scan mode enums and the character codes.
`timescale 1ns / 1ps

module token_descriptor_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [7:0]                   s_tdata,
  input  logic                         s_tlast,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [stts_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [stts_pkg::KIND_W-1:0]  m_tuser,
  output int                           token_backlog,
  output int                           failures
);
  import stts_pkg::*;

  typedef struct packed {
    token_kind_t         kind;
    logic [START_W-1:0]  start;
    logic [VLEN_W-1:0]   len;
  } descriptor_t;

  descriptor_t pending_tokens[$];

  scan_mode_t mode;
  int         column;
  int         tok_start;
  bit         seen_dot;
  bit         colon_last;

  function automatic int next_col(input int c);
    return (c < MAX_LINE - 1) ? c + 1 : MAX_LINE - 1;
  endfunction

  function automatic token_kind_t open_kind();
    if (mode == MODE_KEYWORD) return KIND_KEYWORD;
    if (mode == MODE_STRING) return KIND_STRING;
    return seen_dot ? KIND_REAL : KIND_INTEGER;
  endfunction

  task automatic emit(input token_kind_t kind, input int start, input int len);
    descriptor_t d;
    d.kind  = kind;
    d.start = start[START_W-1:0];
    d.len   = len[VLEN_W-1:0];
    pending_tokens.insert(pending_tokens.size(), d);
  endtask

  task automatic close_token(input token_kind_t kind, input int len);
    token_kind_t k;
    int          l;
    k = kind;
    l = len;
    if (l > 0 && colon_last) begin
      k = KIND_VALUE_KEYWORD;
      l = l - 1;
    end
    mode = MODE_IDLE;
    emit(k, tok_start, l);
  endtask

  task automatic scan_char(input logic [7:0] ch, input logic last);
    int col;
    bit ws;
    col = column;
    ws  = (ch == CH_SPACE || ch == CH_TAB);
    if (mode == MODE_IDLE) begin
      if (ch == CH_STAR || ch == CH_QUOTE) begin
        if (last) begin
          emit((ch == CH_STAR) ? KIND_KEYWORD : KIND_STRING, next_col(col), 0);
        end else begin
          tok_start  = next_col(col);
          colon_last = 0;
          seen_dot   = 0;
          mode       = (ch == CH_STAR) ? MODE_KEYWORD : MODE_STRING;
        end
      end else if (ch == CH_LBRACE) begin
        emit(KIND_OPEN_BRACE, col, 0);
      end else if (ch == CH_RBRACE) begin
        emit(KIND_CLOSE_BRACE, col, 0);
      end else if (ch == CH_MINUS || (ch >= CH_ZERO && ch <= CH_NINE)) begin
        if (last) begin
          emit(KIND_INTEGER, col, 1);
        end else begin
          tok_start  = col;
          colon_last = 0;
          seen_dot   = 0;
          mode       = MODE_NUMBER;
        end
      end
    end else if (mode == MODE_STRING) begin
      if (ch == CH_QUOTE) begin
        close_token(KIND_STRING, col - tok_start);
      end else begin
        colon_last = (ch == CH_COLON);
        if (last) close_token(KIND_STRING, col - tok_start + 1);
      end
    end else if (ws) begin
      close_token(open_kind(), col - tok_start);
    end else begin
      if (mode == MODE_NUMBER && ch == CH_DOT) seen_dot = 1;
      colon_last = (ch == CH_COLON);
      if (last) close_token(open_kind(), col - tok_start + 1);
    end

    if (last) begin
      mode       = MODE_IDLE;
      column     = 0;
      seen_dot   = 0;
      colon_last = 0;
    end else begin
      column = next_col(col);
    end
  endtask

  always @(posedge clk) begin : check_words
    descriptor_t exp_tok;
    if (rst) begin
      mode       = MODE_IDLE;
      column     = 0;
      tok_start  = 0;
      seen_dot   = 0;
      colon_last = 0;
      pending_tokens.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_tokens.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected descriptor: kind %0d start %0d length %0d",
                     m_tuser, m_tdata[START_W-1:0], m_tdata[START_W +: VLEN_W]);
        end else begin
          exp_tok = pending_tokens.pop_front();
          if (exp_tok.kind !== m_tuser || exp_tok.start !== m_tdata[START_W-1:0] ||
              exp_tok.len !== m_tdata[START_W +: VLEN_W]) begin
            failures++;
            if (failures <= 10)
              $display("descriptor mismatch: kind %0d/%0d start %0d/%0d length %0d/%0d",
                       exp_tok.kind, m_tuser, exp_tok.start, m_tdata[START_W-1:0],
                       exp_tok.len, m_tdata[START_W +: VLEN_W]);
          end
        end
      end
      if (s_tvalid && s_tready) scan_char(s_tdata, s_tlast);
    end
    token_backlog = pending_tokens.size();
  end

endmodule

FILE: tb/tb_scene_text_token_scanner.sv
// Testbench top for the scene text token scanner: clock, reset, character
// stimulus, receiver backpressure, watchdog and verdict.
// Depends on stts_pkg, scene_text_token_scanner and token_descriptor_checker.
`timescale 1ns / 1ps

module tb_scene_text_token_scanner;
  import stts_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;

  int token_backlog;
  int failures;
  int src_idle_pct;
  int dst_idle_pct;
  int sent_words;
  int quiet_cycles;
  bit stall_request;

  scene_text_token_scanner i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  token_descriptor_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .s_tlast       (s_axis_tlast),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .m_tuser       (m_axis_tuser),
    .token_backlog (token_backlog),
    .failures      (failures)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hold off for a long stretch on request, otherwise stall at random
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (199) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
        end
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    sent_words++;
  endtask

  function automatic logic [7:0] pick_special();
    case ($urandom_range(10))
      0:       return CH_STAR;
      1:       return CH_QUOTE;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      4:       return CH_MINUS;
      5:       return CH_DOT;
      6:       return CH_COLON;
      7:       return CH_SPACE;
      8:       return CH_TAB;
      9:       return CH_ZERO;
      default: return CH_NINE;
    endcase
  endfunction

  // build one line of tokens (or of noise) and send it, tlast on its final word
  task automatic send_line(input bit well_formed);
    logic [7:0] line_q[$];
    int         n_tok;
    int         n;
    int         dot_at;
    if (well_formed) begin
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
        case ($urandom_range(7))
          0: begin
            line_q = {line_q, CH_STAR};
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) line_q = {line_q, 8'(8'h61 + $urandom_range(25))};
            if ($urandom_range(2) == 0) line_q = {line_q, CH_COLON};
          end
          1: line_q = {line_q, CH_LBRACE};
          2: line_q = {line_q, CH_RBRACE};
          3, 7: begin
            line_q = {line_q, ($urandom_range(3) == 0) ?
                              CH_MINUS : 8'(CH_ZERO + $urandom_range(9))};
            n      = $urandom_range(0, 5);
            dot_at = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
              if (i == dot_at) line_q = {line_q, CH_DOT};
              else line_q = {line_q, 8'(CH_ZERO + $urandom_range(9))};
            end
            if ($urandom_range(5) == 0) line_q = {line_q, CH_COLON};
          end
          4: begin
            line_q = {line_q, CH_QUOTE};
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
              case ($urandom_range(3))
                0:       line_q = {line_q, pick_special()};
                1:       line_q = {line_q, 8'($urandom_range(255))};
                default: line_q = {line_q, 8'(8'h41 + $urandom_range(25))};
              endcase
            end
            if ($urandom_range(3) == 0) line_q = {line_q, CH_COLON};
            if ($urandom_range(4) != 0) line_q = {line_q, CH_QUOTE};
          end
          5: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) line_q = {line_q, 8'($urandom_range(255))};
          end
          default: line_q = {line_q, CH_SPACE};
        endcase
        case ($urandom_range(9))
          0, 1:    ;
          2, 3:    line_q = {line_q, CH_TAB};
          default: line_q = {line_q, CH_SPACE};
        endcase
      end
    end else begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        line_q = {line_q, ($urandom_range(1) == 0) ?
                          pick_special() : 8'($urandom_range(255))};
    end
    foreach (line_q[i]) send_word(line_q[i], i == line_q.size() - 1);
  endtask

  logic [8:0] directed_words[$];

  initial begin
    int phase_target;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    src_idle_pct  = 27;
    dst_idle_pct  = 61;
    stall_request = 1'b0;
    sent_words    = 0;
    quiet_cycles  = 0;
    directed_words = '{
      {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_LBRACE}, {1'b0, CH_RBRACE},
      {1'b0, CH_STAR}, {1'b0, 8'h61}, {1'b0, CH_COLON}, {1'b0, CH_TAB},
      {1'b0, CH_MINUS}, {1'b0, 8'h31}, {1'b0, CH_DOT}, {1'b0, 8'h35},
      {1'b0, CH_SPACE}, {1'b0, 8'h37}, {1'b1, CH_SPACE},
      {1'b1, CH_STAR}, {1'b1, CH_QUOTE}, {1'b1, 8'h33},
      {1'b0, CH_QUOTE}, {1'b0, 8'h78}, {1'b1, CH_COLON},
      {1'b0, CH_QUOTE}, {1'b0, 8'h71}, {1'b1, CH_QUOTE}
    };
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) send_word(directed_words[i][7:0], directed_words[i][8]);

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 61 : 0;
      dst_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 27 : 0;
      phase_target = sent_words + 50;
      if (phase != 1) stall_request = 1'b1;
      while (sent_words < phase_target) send_line($urandom_range(9) < 8);
      if (phase == 2) begin
        // saturate the column: a real number past the last column closed by a
        // space, then tokens that all start on the last column
        send_word(CH_MINUS, 1'b0);
        for (int i = 0; i < 1029; i++)
          send_word((i == 500) ? CH_DOT : 8'(CH_ZERO + $urandom_range(9)), 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(CH_COLON, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_LBRACE, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h62, 1'b1);
      end
      s_axis_tvalid <= 1'b0;
      while (token_backlog != 0) @(negedge clk);
    end

    repeat (20) @(negedge clk);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
